// ===== design/sioff_pkg.sv =====
// Shared types and helpers for the sorted interval overlap finder.
// Holds the channel word structs, the internal stage structs and the size class function.
// No dependencies.
package sioff_pkg;

	localparam int OFF_W   = 63;
	localparam int LEN_W   = 32;
	localparam int END_W   = 64;
	localparam int CLASS_W = 6;

	typedef struct packed {
		logic             first;
		logic [OFF_W-1:0] range_offset;
		logic [LEN_W-1:0] range_length;
	} range_word_t;

	typedef struct packed {
		logic [OFF_W-1:0]   overlap_offset;
		logic [LEN_W-1:0]   overlap_length;
		logic [CLASS_W-1:0] size_class;
	} overlap_word_t;

	// One range as the sweep sees it: start and exclusive end.
	typedef struct packed {
		logic             first;
		logic [END_W-1:0] start;
		logic [END_W-1:0] stop;
	} sweep_item_t;

	typedef struct packed {
		logic             hit;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
	} sweep_result_t;

	// Ceiling log2 of a nonzero length: bit length of (len - 1).
	function automatic logic [CLASS_W-1:0] size_class_of(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0]   lm1;
		logic [CLASS_W-1:0] c;
		lm1 = len - {{(LEN_W-1){1'b0}}, 1'b1};
		c = '0;
		for (int i = 0; i < LEN_W; i++) begin
			if (lm1[i]) begin
				c = CLASS_W'(i + 1);
			end
		end
		return c;
	endfunction

endpackage

// ===== design/sioff_sweep.sv =====
// Sweep state (coverage end, reported end) and the overlap decision for one range.
// Depends on sioff_pkg for the item and result structs.
module sioff_sweep #(
	parameter int LEN_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  sioff_pkg::sweep_item_t item,
	output sioff_pkg::sweep_result_t result
);

	localparam logic [sioff_pkg::END_W-1:0] LenMask =
		(sioff_pkg::END_W'(1) << LEN_BITS) - sioff_pkg::END_W'(1);

	logic [sioff_pkg::END_W-1:0] cov_q, rep_q;
	logic                        any_q;
	logic [sioff_pkg::END_W-1:0] cov_d, rep_d;
	logic                        any_d;

	logic [sioff_pkg::END_W-1:0] cov_base, rep_base;
	logic                        any_base;
	logic [sioff_pkg::END_W-1:0] ov_off, ov_end, diff, sat;
	logic                        hit;

	always_comb begin
		// a first range starts a fresh sweep
		cov_base = item.first ? '0 : cov_q;
		rep_base = item.first ? '0 : rep_q;
		any_base = item.first ? 1'b0 : any_q;

		cov_d  = cov_base;
		rep_d  = rep_base;
		any_d  = any_base;
		hit    = 1'b0;
		ov_off = item.start;
		ov_end = item.stop;
		diff   = '0;
		sat    = '0;

		if (item.start >= cov_base) begin
			cov_d = item.stop;
		end else begin
			if (item.stop > cov_base) begin
				ov_end = cov_base;
				cov_d  = item.stop;
			end
			hit = 1'b1;
			// trim the front of the overlap against what was already reported
			if (any_base && rep_base > item.start) begin
				if (rep_base >= ov_end) begin
					hit = 1'b0;
				end else begin
					ov_off = rep_base;
				end
			end
			diff = ov_end - ov_off;
			if (diff == '0) begin
				hit = 1'b0;
			end
			sat = (diff > LenMask) ? LenMask : diff;
			if (hit) begin
				rep_d = ov_off + sat;
				any_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q <= '0;
			rep_q <= '0;
			any_q <= 1'b0;
		end else if (en) begin
			cov_q <= cov_d;
			rep_q <= rep_d;
			any_q <= any_d;
		end
	end

	assign result.hit    = hit;
	assign result.offset = ov_off[sioff_pkg::OFF_W-1:0];
	assign result.length = sat[sioff_pkg::LEN_W-1:0];

endmodule

// ===== design/sorted_interval_overlap_finder.sv =====
// Top level of the sorted interval overlap finder: input stage, sweep, result stage.
// Depends on sioff_pkg and sioff_sweep.
//
// Usage:
//   range channel: range_valid/range_ready/range_word carry one byte range per
//   word (first flag, offset, length). Ranges of one list arrive sorted by
//   offset; first = 1 on a word restarts the sweep before that range is used.
//   Only the low LEN_BITS bits of range_length count.
//   overlap channel: overlap_valid/overlap_ready/overlap_word carry zero or one
//   word per range: the newly overlapped part (offset, length) and its
//   ceiling log2 size class.
// Throughput: one range per cycle while overlap_ready is high; the sweep state
//   update is compare and subtract logic between the input stage and the
//   result stage.
// Path: a range goes from the input stage through the sweep and res_s2 into the
//   result stage on overlap_valid. Ranges with no overlap leave no word there.
// Reset: arst_n clears the sweep state and empties all stages.
// Stall: while overlap_ready is low the stages fill; range_ready drops only
//   when every stage holds a word, and nothing is lost or repeated.
module sorted_interval_overlap_finder #(
	parameter int LEN_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     range_valid,
	output logic                     range_ready,
	input  sioff_pkg::range_word_t   range_word,
	output logic                     overlap_valid,
	input  logic                     overlap_ready,
	output sioff_pkg::overlap_word_t overlap_word
);

	localparam logic [sioff_pkg::LEN_W-1:0] LenMask =
		sioff_pkg::LEN_W'((64'd1 << LEN_BITS) - 64'd1);

	logic                      s1_valid_q;
	sioff_pkg::sweep_item_t    item_s1;
	logic                      s2_valid_q;
	sioff_pkg::sweep_result_t  res_s2;
	sioff_pkg::sweep_result_t  res;
	logic                      out_valid_q;
	sioff_pkg::overlap_word_t  out_q;

	logic out_adv, s2_adv, s1_adv;

	assign out_adv     = !out_valid_q || overlap_ready;
	assign s2_adv      = !s2_valid_q || out_adv;
	assign s1_adv      = !s1_valid_q || s2_adv;
	assign range_ready = s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				s1_valid_q <= range_valid;
			end
			if (s2_adv) begin
				s2_valid_q <= s1_valid_q && res.hit;
			end
			if (out_adv) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	// input stage: precompute the exclusive end of the range
	always_ff @(posedge clk) begin
		if (s1_adv && range_valid) begin
			item_s1.first <= range_word.first;
			item_s1.start <= {1'b0, range_word.range_offset};
			item_s1.stop  <= {1'b0, range_word.range_offset}
				+ {{(sioff_pkg::END_W-sioff_pkg::LEN_W){1'b0}},
				   range_word.range_length & LenMask};
		end
	end

	sioff_sweep #(
		.LEN_BITS(LEN_BITS)
	) u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (s1_valid_q && s2_adv),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			res_s2 <= res;
		end
	end

	// result stage: add the size class
	always_ff @(posedge clk) begin
		if (out_adv && s2_valid_q) begin
			out_q.overlap_offset <= res_s2.offset;
			out_q.overlap_length <= res_s2.length;
			out_q.size_class     <= sioff_pkg::size_class_of(res_s2.length);
		end
	end

	assign overlap_valid = out_valid_q;
	assign overlap_word  = out_q;

endmodule
